>>> rtl/cdda_pkg.sv
package cdda_pkg;

  // Calendar constants
  localparam int MONTHS        = 12;
  localparam int DAYS_PER_YEAR = 365;
  localparam int LEAP_CYCLE    = 4;
  localparam int CENTURY       = 100;
  localparam int RESET_YEAR    = 2000;

  // Distance field
  localparam int                DIST_W   = 21;
  localparam logic [DIST_W-1:0] DIST_MAX = 21'd2097151;

  // Divisibility by 25 through the odd inverse: y * INV25 (mod 2^16) is at
  // most DIV25_LIM exactly when y is a multiple of 25.
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  // Month lengths (February in a common year) and days before each month.
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };
  localparam logic [8:0] CUM_DAYS [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
  };

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_CMP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_ADD,
    DP_SUB,
    DP_SUBFIX,
    DP_ACC_SET,
    DP_ACC_ADD,
    DP_CMP_FIN
  } dp_op_t;

  typedef enum logic [2:0] {
    TERM_Y365,
    TERM_Y4,
    TERM_C100,
    TERM_C400,
    TERM_MON,
    TERM_DAY
  } term_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CNT_LEFT,
    COND_SUB_MOVED
  } cond_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    dp_op_t op;
    term_t  term;
    logic   sel_event;
    logic   negate;
    cond_t  cond;
    upc_t   target;
    logic   fin;
  } uword_t;

  // Program layout
  localparam upc_t UA_LOAD   = 5'd0;
  localparam upc_t UA_ADD    = 5'd1;
  localparam upc_t UA_SUB    = 5'd2;
  localparam upc_t UA_SUBFIX = 5'd3;
  localparam upc_t UA_CMP    = 5'd4;
  localparam int   PROG_LEN  = 17;

  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] p;
    logic        by4;
    logic        by16;
    logic        by25;
    p    = y * INV25;
    by4  = (y[1:0] == 2'd0);
    by16 = (y[3:0] == 4'd0);
    by25 = (p <= DIV25_LIM);
    return by4 && (!by25 || by16);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
    logic [4:0] n;
    n = MONTH_LEN[m];
    if (m == 4'd2 && lp) begin
      n = n + 5'd1;
    end
    return n;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m, input logic lp);
    return CUM_DAYS[m] + 9'((lp && m > 4'd2) ? 1 : 0);
  endfunction

  function automatic upc_t entry(input op_t op);
    upc_t a;
    unique case (op)
      OP_LOAD: a = UA_LOAD;
      OP_ADD:  a = UA_ADD;
      OP_SUB:  a = UA_SUB;
      OP_CMP:  a = UA_CMP;
      default: a = UA_LOAD;
    endcase
    return a;
  endfunction

  // Control store. Compare builds serial(stored) - serial(event) in the
  // accumulator, one term per step.
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    unique case (a)
      UA_LOAD:       w = '{DP_LOAD,    TERM_DAY,  1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b1};
      UA_ADD:        w = '{DP_ADD,     TERM_DAY,  1'b0, 1'b0, COND_CNT_LEFT,  UA_ADD,    1'b1};
      UA_SUB:        w = '{DP_SUB,     TERM_DAY,  1'b0, 1'b0, COND_SUB_MOVED, UA_SUBFIX, 1'b1};
      UA_SUBFIX:     w = '{DP_SUBFIX,  TERM_DAY,  1'b0, 1'b0, COND_ALWAYS,    UA_SUB,    1'b0};
      UA_CMP:        w = '{DP_ACC_SET, TERM_Y365, 1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd1: w = '{DP_ACC_ADD, TERM_Y4,   1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd2: w = '{DP_ACC_ADD, TERM_C100, 1'b0, 1'b1, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd3: w = '{DP_ACC_ADD, TERM_C400, 1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd4: w = '{DP_ACC_ADD, TERM_MON,  1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd5: w = '{DP_ACC_ADD, TERM_DAY,  1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd6: w = '{DP_ACC_ADD, TERM_Y365, 1'b1, 1'b1, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd7: w = '{DP_ACC_ADD, TERM_Y4,   1'b1, 1'b1, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd8: w = '{DP_ACC_ADD, TERM_C100, 1'b1, 1'b0, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd9: w = '{DP_ACC_ADD, TERM_C400, 1'b1, 1'b1, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd10: w = '{DP_ACC_ADD, TERM_MON, 1'b1, 1'b1, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd11: w = '{DP_ACC_ADD, TERM_DAY, 1'b1, 1'b1, COND_NEVER,     UA_LOAD,   1'b0};
      UA_CMP + 5'd12: w = '{DP_CMP_FIN, TERM_DAY, 1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b1};
      default:       w = '{DP_NOP,     TERM_DAY,  1'b0, 1'b0, COND_NEVER,     UA_LOAD,   1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/cdda_term.sv
module cdda_term #(
  parameter int YEAR_BITS = 12,
  parameter int ACC_W     = 23
) (
  input  logic [YEAR_BITS-1:0] year,
  input  logic [3:0]           month,
  input  logic [4:0]           day,
  input  logic                 leap,
  input  cdda_pkg::term_t      term_sel,
  output logic [ACC_W-1:0]     term_val
);
  import cdda_pkg::*;

  // Divide by 100 with a reciprocal: exact for every operand below 2^X_W.
  localparam int              X_W   = YEAR_BITS + 1;
  localparam int              DIV_K = YEAR_BITS + 8;
  localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + CENTURY - 1) / CENTURY;
  localparam int              M_W   = DIV_K - 6;
  localparam int              P_W   = X_W + M_W;

  logic [X_W:0]     y400;
  logic [X_W-1:0]   y100;
  logic [X_W-1:0]   y4;
  logic [X_W-1:0]   x;
  logic [P_W-1:0]   prod;
  logic [ACC_W-1:0] t365;

  assign y400 = (X_W + 1)'(year) + (X_W + 1)'(LEAP_CYCLE * CENTURY - 1);
  assign y100 = X_W'(year) + X_W'(CENTURY - 1);
  assign y4   = (X_W'(year) + X_W'(LEAP_CYCLE - 1)) >> 2;
  assign x    = (term_sel == TERM_C400) ? X_W'(y400 >> 2) : y100;
  assign prod = P_W'(x) * P_W'(DIV_M);
  assign t365 = ACC_W'(year) * ACC_W'(DAYS_PER_YEAR);

  always_comb begin
    unique case (term_sel)
      TERM_Y365: term_val = t365;
      TERM_Y4:   term_val = ACC_W'(y4);
      TERM_C100,
      TERM_C400: term_val = ACC_W'(prod[P_W-1:DIV_K]);
      TERM_MON:  term_val = ACC_W'(days_before(month, leap));
      TERM_DAY:  term_val = ACC_W'(day);
      default:   term_val = '0;
    endcase
  end

endmodule

>>> rtl/calendar_date_day_arithmetic_core.sv
// Calendar date unit: holds one Gregorian date (reset 1 January 2000, year
// taken modulo 2^YEAR_BITS) and runs one command per input beat: load a date
// (a bad month or day becomes 1), add or subtract a day count (taken modulo
// 2^COUNT_BITS), or compare with an event date, giving the day distance
// (saturating at 2097151) and whether the stored date comes first. Every beat
// yields exactly one result beat with the stored date and its leap flag.
// A small microprogram steps a shared datapath; the step loop sets the rate.
// Add and subtract take a step per month boundary crossed, since the date
// moves one month per step (subtract refills the day of the new month in a
// second step). A full 65535-day add crosses about 2150 months. One item is
// in flight at a time; a finished result waits in the output register while
// the next beat enters.
module calendar_date_day_arithmetic_core #(
  parameter int YEAR_BITS  = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [4:0]                  day,
  input  logic [3:0]                  month,
  input  logic [YEAR_BITS-1:0]        year,
  input  logic [COUNT_BITS-1:0]       count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  cur_day,
  output logic [3:0]                  cur_month,
  output logic [YEAR_BITS-1:0]        cur_year,
  output logic                        leap,
  output logic                        is_earlier,
  output logic [cdda_pkg::DIST_W-1:0] distance
);
  import cdda_pkg::*;

  // Accumulator wide enough for a signed difference of two day serials and
  // for the saturation compare.
  localparam int ACC_W = (YEAR_BITS + 11 > DIST_W + 1) ? YEAR_BITS + 11 : DIST_W + 1;
  localparam int SUM_W = COUNT_BITS + 1;

  // Sequencer
  seq_state_t state, state_next;
  upc_t       upc, upc_next;
  uword_t     uw;
  logic       in_accept;
  logic       run;
  logic       jump;
  logic       step_done;
  logic       emit_go;

  // Stored date and item registers
  logic [4:0]            day_reg, day_next;
  logic [3:0]            month_reg, month_next;
  logic [YEAR_BITS-1:0]  year_reg, year_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic [4:0]            ev_day;
  logic [3:0]            ev_month;
  logic [YEAR_BITS-1:0]  ev_year;
  logic [ACC_W-1:0]      acc, acc_next;
  logic                  cmp_earlier, cmp_earlier_next;
  logic [DIST_W-1:0]     cmp_dist, cmp_dist_next;

  // Datapath nets
  logic                  leap_cur;
  logic [4:0]            mx_cur;
  logic                  ev_leap;
  logic [3:0]            ev_month_fix;
  logic [4:0]            ev_mx;
  logic [4:0]            ev_day_fix;
  logic [SUM_W-1:0]      add_sum;
  logic                  add_over;
  logic                  sub_moved;
  logic [ACC_W-1:0]      term_val;
  logic [ACC_W-1:0]      mag;

  assign uw        = ucode(upc);
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Sequencer: next state and control outputs
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (in_valid) begin
        state_next = SEQ_RUN;
      end
      SEQ_RUN: if (step_done) begin
        state_next = SEQ_EMIT;
      end
      SEQ_EMIT: if (emit_go) begin
        state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != SEQ_IDLE);
    run       = (state == SEQ_RUN);
    emit_go   = (state == SEQ_EMIT) && (!out_valid || !out_stall);
    step_done = run && !jump && uw.fin;
  end

  // Branch: taken goes to the target, otherwise fall through to the next word
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_CNT_LEFT:  jump = (cnt_next != '0);
      COND_SUB_MOVED: jump = sub_moved;
      default:        jump = 1'b0;
    endcase
    upc_next = jump ? uw.target : upc + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      upc   <= UA_LOAD;
    end else begin
      state <= state_next;
      if (in_accept) begin
        upc <= entry(op_t'(opcode));
      end else if (run) begin
        upc <= upc_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Date checks
  // ---------------------------------------------------------------------
  assign leap_cur = is_leap(16'(year_reg));
  assign mx_cur   = days_in(month_reg, leap_cur);

  // Repair the event date: bad month first, then a day outside that month
  assign ev_leap      = is_leap(16'(ev_year));
  assign ev_month_fix = (ev_month < 4'd1 || ev_month > 4'(MONTHS)) ? 4'd1 : ev_month;
  assign ev_mx        = days_in(ev_month_fix, ev_leap);
  assign ev_day_fix   = (ev_day == 5'd0 || ev_day > ev_mx) ? 5'd1 : ev_day;

  // Add: either finish inside this month or jump to the 1st of the next
  assign add_sum   = SUM_W'(cnt) + SUM_W'(day_reg);
  assign add_over  = add_sum > SUM_W'(mx_cur);
  // Subtract: the count reaches back past the 1st, into the previous month
  assign sub_moved = cnt >= COUNT_BITS'(day_reg);

  cdda_term #(
    .YEAR_BITS (YEAR_BITS),
    .ACC_W     (ACC_W)
  ) u_term (
    .year     (uw.sel_event ? ev_year : year_reg),
    .month    (uw.sel_event ? ev_month_fix : month_reg),
    .day      (uw.sel_event ? ev_day_fix : day_reg),
    .leap     (uw.sel_event ? ev_leap : leap_cur),
    .term_sel (uw.term),
    .term_val (term_val)
  );

  assign mag = acc[ACC_W-1] ? ACC_W'(-acc) : acc;

  // ---------------------------------------------------------------------
  // Datapath step selected by the control word
  // ---------------------------------------------------------------------
  always_comb begin
    day_next         = day_reg;
    month_next       = month_reg;
    year_next        = year_reg;
    cnt_next         = cnt;
    acc_next         = acc;
    cmp_earlier_next = cmp_earlier;
    cmp_dist_next    = cmp_dist;
    unique case (uw.op)
      DP_NOP: begin
      end
      DP_LOAD: begin
        day_next   = ev_day_fix;
        month_next = ev_month_fix;
        year_next  = ev_year;
      end
      DP_ADD: begin
        if (add_over) begin
          cnt_next = COUNT_BITS'(add_sum - SUM_W'(mx_cur) - SUM_W'(1));
          day_next = 5'd1;
          if (month_reg < 4'(MONTHS)) begin
            month_next = month_reg + 4'd1;
          end else begin
            month_next = 4'd1;
            year_next  = year_reg + YEAR_BITS'(1);
          end
        end else begin
          day_next = 5'(add_sum);
          cnt_next = '0;
        end
      end
      DP_SUB: begin
        if (sub_moved) begin
          cnt_next = cnt - COUNT_BITS'(day_reg);
          if (month_reg <= 4'd1) begin
            month_next = 4'(MONTHS);
            year_next  = year_reg - YEAR_BITS'(1);
          end else begin
            month_next = month_reg - 4'd1;
          end
        end else begin
          day_next = day_reg - 5'(cnt);
          cnt_next = '0;
        end
      end
      DP_SUBFIX: begin
        // Land on the last day of the month just entered
        day_next = mx_cur;
      end
      DP_ACC_SET: begin
        acc_next = uw.negate ? ACC_W'(-term_val) : term_val;
      end
      DP_ACC_ADD: begin
        acc_next = uw.negate ? acc - term_val : acc + term_val;
      end
      DP_CMP_FIN: begin
        cmp_earlier_next = acc[ACC_W-1];
        cmp_dist_next    = (mag > ACC_W'(DIST_MAX)) ? DIST_MAX : mag[DIST_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Stored date: advance only while the program runs
  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= 5'd1;
      month_reg <= 4'd1;
      year_reg  <= YEAR_BITS'(RESET_YEAR);
    end else if (run) begin
      day_reg   <= day_next;
      month_reg <= month_next;
      year_reg  <= year_next;
    end
  end

  // Item payload: capture the beat, then let the steps work on it
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ev_day      <= day;
      ev_month    <= month;
      ev_year     <= year;
      cnt         <= count;
      cmp_earlier <= 1'b0;
      cmp_dist    <= '0;
    end else if (run) begin
      cnt         <= cnt_next;
      acc         <= acc_next;
      cmp_earlier <= cmp_earlier_next;
      cmp_dist    <= cmp_dist_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: hold the result beat until it is taken
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      cur_day    <= day_reg;
      cur_month  <= month_reg;
      cur_year   <= year_reg;
      leap       <= leap_cur;
      is_earlier <= cmp_earlier;
      distance   <= cmp_dist;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    month_reg >= 4'd1 && month_reg <= 4'(MONTHS))
    else $error("stored month out of range");

  a_day_range_idle: assert property (@(posedge clk) disable iff (rst)
    state == SEQ_IDLE |-> day_reg >= 5'd1 && day_reg <= mx_cur)
    else $error("stored day outside its month between items");

  a_upc_in_program: assert property (@(posedge clk) disable iff (rst)
    state == SEQ_RUN |-> upc < upc_t'(PROG_LEN))
    else $error("microprogram counter left the program");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> out_valid)
    else $error("finished item did not reach the output register");

  a_earlier_has_distance: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !is_earlier || distance != '0)
    else $error("earlier date reported with zero distance");

endmodule

>>> tb/calendar_checker.sv
`timescale 1ns / 100ps

module calendar_checker #(
  parameter int YEAR_BITS  = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [4:0]                  day,
  input  logic [3:0]                  month,
  input  logic [YEAR_BITS-1:0]        year,
  input  logic [COUNT_BITS-1:0]       count,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [4:0]                  cur_day,
  input  logic [3:0]                  cur_month,
  input  logic [YEAR_BITS-1:0]        cur_year,
  input  logic                        leap,
  input  logic                        is_earlier,
  input  logic [cdda_pkg::DIST_W-1:0] distance,
  output int                          fail_count,
  output int                          outstanding
);
  import cdda_pkg::*;

  localparam longint YEAR_MOD = longint'(1) << YEAR_BITS;

  typedef struct packed {
    logic [4:0]           d;
    logic [3:0]           m;
    logic [YEAR_BITS-1:0] y;
    logic                 lp;
    logic                 earlier;
    logic [DIST_W-1:0]    span;
  } date_result_t;

  date_result_t expected_dates[$];

  int unsigned shadow_day   = 1;
  int unsigned shadow_month = 1;
  int unsigned shadow_year  = RESET_YEAR % YEAR_MOD;
  int          mismatch_total = 0;
  int          results_seen   = 0;

  assign fail_count = mismatch_total;

  function automatic bit gregorian_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = gregorian_leap(y) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  // Days since the start of year 0, with no year wrap.
  function automatic longint day_number(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
    longint      yy;
    longint      n;
    int unsigned i;
    yy = y;
    n  = yy * 365 + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
    for (i = 1; i < m; i++) n += month_length(i, y);
    return n + d;
  endfunction

  task automatic repair_date(inout int unsigned d, inout int unsigned m, input int unsigned y);
    if (m < 1 || m > 12) m = 1;
    if (d < 1 || d > month_length(m, y)) d = 1;
  endtask

  task automatic step_calendar(input op_t op, input int unsigned d_in, input int unsigned m_in,
                               input int unsigned y_in, input int unsigned c_in,
                               output date_result_t r);
    int unsigned d;
    int unsigned m;
    int unsigned c;
    int unsigned mx;
    longint      a;
    longint      b;
    longint      diff;
    bit          earlier;
    d       = d_in;
    m       = m_in;
    c       = c_in;
    earlier = 1'b0;
    diff    = 0;
    case (op)
      OP_LOAD: begin
        repair_date(d, m, y_in);
        shadow_day   = d;
        shadow_month = m;
        shadow_year  = y_in;
      end
      OP_ADD: begin
        while (c > 0) begin
          mx = month_length(shadow_month, shadow_year);
          if (shadow_day + c > mx) begin
            c -= mx - shadow_day + 1;
            shadow_day = 1;
            if (shadow_month < 12) begin
              shadow_month++;
            end else begin
              shadow_month = 1;
              shadow_year  = (shadow_year + 1) % YEAR_MOD;
            end
          end else begin
            shadow_day += c;
            c = 0;
          end
        end
      end
      OP_SUB: begin
        while (c > 0) begin
          if (c >= shadow_day) begin
            c -= shadow_day;
            if (shadow_month <= 1) begin
              shadow_month = 12;
              shadow_year  = (shadow_year + YEAR_MOD - 1) % YEAR_MOD;
            end else begin
              shadow_month--;
            end
            shadow_day = month_length(shadow_month, shadow_year);
          end else begin
            shadow_day -= c;
            c = 0;
          end
        end
      end
      default: begin
        repair_date(d, m, y_in);
        a       = day_number(shadow_day, shadow_month, shadow_year);
        b       = day_number(d, m, y_in);
        earlier = (a < b);
        diff    = earlier ? b - a : a - b;
        if (diff > DIST_MAX) diff = DIST_MAX;
      end
    endcase
    r.d       = 5'(shadow_day);
    r.m       = 4'(shadow_month);
    r.y       = YEAR_BITS'(shadow_year);
    r.lp      = gregorian_leap(shadow_year);
    r.earlier = earlier;
    r.span    = DIST_W'(diff);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("date result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
    mismatch_total++;
  endtask

  // Retire the output beat before predicting the input beat, so a result can
  // never be matched against an item that entered on the same edge.
  always @(posedge clk) begin
    date_result_t want;
    date_result_t fresh;
    if (rst) begin
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_dates.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_dates.pop_front();
          if (cur_day !== want.d)          report_mismatch("cur_day", cur_day, want.d);
          if (cur_month !== want.m)        report_mismatch("cur_month", cur_month, want.m);
          if (cur_year !== want.y)         report_mismatch("cur_year", cur_year, want.y);
          if (leap !== want.lp)            report_mismatch("leap", leap, want.lp);
          if (is_earlier !== want.earlier) report_mismatch("is_earlier", is_earlier, want.earlier);
          if (distance !== want.span)      report_mismatch("distance", distance, want.span);
        end
      end
      if (in_valid && !in_stall) begin
        step_calendar(op_t'(opcode), day, month, year, count, fresh);
        expected_dates.push_back(fresh);
      end
      outstanding <= expected_dates.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cdda_pkg::*;

  localparam int YEAR_BITS   = 12;
  localparam int COUNT_BITS  = 16;
  localparam int ITEM_TARGET = 1550;
  // Worst case is a few dozen full-range subtracts plus a few hundred
  // mid-size shifts; this leaves a wide margin on top.
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            opcode;
  logic [4:0]            day;
  logic [3:0]            month;
  logic [YEAR_BITS-1:0]  year;
  logic [COUNT_BITS-1:0] count;
  logic                  out_valid;
  logic                  out_stall;
  logic [4:0]            cur_day;
  logic [3:0]            cur_month;
  logic [YEAR_BITS-1:0]  cur_year;
  logic                  leap;
  logic                  is_earlier;
  logic [DIST_W-1:0]     distance;

  int fail_count;
  int outstanding;
  int items_sent    = 0;
  bit sender_steady = 1'b0;

  calendar_date_day_arithmetic_core #(
    .YEAR_BITS (YEAR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .day       (day),
    .month     (month),
    .year      (year),
    .count     (count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cur_day   (cur_day),
    .cur_month (cur_month),
    .cur_year  (cur_year),
    .leap      (leap),
    .is_earlier(is_earlier),
    .distance  (distance)
  );

  calendar_checker #(
    .YEAR_BITS (YEAR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) date_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .day        (day),
    .month      (month),
    .year       (year),
    .count      (count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cur_day    (cur_day),
    .cur_month  (cur_month),
    .cur_year   (cur_year),
    .leap       (leap),
    .is_earlier (is_earlier),
    .distance   (distance),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one command beat. Draw an idle gap first (none while the sender is
  // in a steady stretch), then hold the beat until the block takes it. The
  // task returns in the step of the accepting edge, so a back-to-back beat
  // keeps in_valid high with a single assignment in that step.
  task automatic send_command(input op_t op, input int unsigned d, input int unsigned m,
                              input int unsigned y, input int unsigned c);
    int gap;
    if (items_sent % 50 == 0) sender_steady = ($urandom_range(0, 3) == 0);
    gap = sender_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    day      <= 5'(d);
    month    <= 4'(m);
    year     <= YEAR_BITS'(y);
    count    <= COUNT_BITS'(c);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Bias years toward the interesting spots: both ends of the wrap, century
  // years (leap only every fourth one) and the modern range.
  function automatic int unsigned pick_year();
    int unsigned y;
    case ($urandom_range(0, 9))
      0, 1:    y = $urandom_range(0, 4095);
      2:       y = $urandom_range(0, 3);
      3:       y = $urandom_range(4092, 4095);
      4:       y = $urandom_range(0, 40) * 100;
      5:       y = $urandom_range(0, 10) * 400;
      default: y = $urandom_range(1890, 2110);
    endcase
    return y;
  endfunction

  // Mostly legal months; now and then zero or one of the unused codes above 12.
  function automatic int unsigned pick_month();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 12);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
  endfunction

  // Keep day counts small so shifts stay cheap; only a few use the full range.
  function automatic int unsigned pick_shift();
    int unsigned r;
    int unsigned c;
    r = $urandom_range(0, 99);
    if (r < 2)       c = $urandom_range(0, 65535);
    else if (r < 12) c = $urandom_range(0, 4095);
    else if (r < 20) c = $urandom_range(0, 3);
    else             c = $urandom_range(0, 400);
    return c;
  endfunction

  // Shift commands carry random date fields and load or compare commands a
  // random count: the block must ignore them.
  task automatic send_shift(input op_t op);
    send_command(op, $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 4095),
                 pick_shift());
  endtask

  initial begin
    int          kind;
    int          r;
    int unsigned ld;
    int unsigned lm;
    int unsigned ly;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= OP_LOAD;
    day       <= '0;
    month     <= '0;
    year      <= '0;
    count     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: compare against the reset date, zero shifts, the leap rule at
    // century years and at year 0, repair of bad days and months, wrap of the
    // year in both directions, month ends, full-range counts and far compares.
    send_command(OP_CMP, 1, 1, 2000, 0);
    send_command(OP_ADD, 31, 15, 4095, 0);
    send_command(OP_SUB, 0, 0, 0, 0);
    send_command(OP_LOAD, 29, 2, 2000, 65535);
    send_command(OP_LOAD, 29, 2, 1900, 0);
    send_command(OP_LOAD, 29, 2, 2100, 0);
    send_command(OP_LOAD, 29, 2, 0, 0);
    send_command(OP_LOAD, 0, 0, 0, 0);
    send_command(OP_LOAD, 31, 4, 2023, 0);
    send_command(OP_LOAD, 31, 15, 4095, 0);
    send_command(OP_LOAD, 31, 12, 4095, 0);
    send_command(OP_ADD, 0, 0, 0, 1);
    send_command(OP_SUB, 0, 0, 0, 1);
    send_command(OP_LOAD, 1, 3, 2024, 0);
    send_command(OP_SUB, 0, 0, 0, 1);
    send_command(OP_ADD, 0, 0, 0, 65535);
    send_command(OP_SUB, 0, 0, 0, 65535);
    send_command(OP_LOAD, 1, 1, 0, 0);
    send_command(OP_CMP, 31, 12, 4095, 0);
    send_command(OP_CMP, 0, 0, 0, 65535);
    send_command(OP_LOAD, 31, 12, 4095, 0);
    send_command(OP_CMP, 1, 1, 0, 0);
    send_command(OP_CMP, 30, 2, 2024, 0);

    // Random: mostly a load followed by a short run of shifts and compares,
    // with some runs that start at the edges of the year range so the wrap
    // is taken often, and some that skip the load and keep walking.
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      ld   = $urandom_range(0, 31);
      lm   = pick_month();
      ly   = pick_year();
      if (kind == 8) begin
        lm = 1;
        ly = $urandom_range(0, 1);
      end else if (kind == 9) begin
        lm = 12;
        ly = $urandom_range(4094, 4095);
      end
      if (kind != 7) send_command(OP_LOAD, ld, lm, ly, $urandom_range(0, 65535));
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 9);
        if (kind == 8 && r < 6)      send_shift(OP_SUB);
        else if (kind == 9 && r < 6) send_shift(OP_ADD);
        else if (r < 4)              send_shift(OP_ADD);
        else if (r < 8)              send_shift(OP_SUB);
        else if (r == 8)
          send_command(OP_CMP, $urandom_range(0, 31), pick_month(), pick_year(),
                       $urandom_range(0, 65535));
        else
          send_command(OP_CMP, ld, lm, ly, $urandom_range(0, 65535));
      end
    end
    in_valid <= 1'b0;

    // Let the last prediction land, wait for every result, then keep watching
    // for a stray beat.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: draw a stall per beat, with steady stretches and two long
  // hold-offs that back the block up until it stalls its input.
  initial begin
    int hold;
    int beats;
    bit steady;
    out_stall <= 1'b0;
    beats  = 0;
    steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (beats % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (beats == 40 || beats == 900) hold = LONG_HOLD;
      else                             hold = steady ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      beats++;
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
